// File: rtl/crw_pkg.sv
`default_nettype none

package crw_pkg;

  localparam int unsigned SampleWidth = 10;
  localparam int unsigned LevelWidth  = 8;
  localparam int unsigned PinWidth    = 3;

  // Wheel segment boundaries
  localparam logic [SampleWidth-1:0] SegRange = 10'd170;
  localparam logic [SampleWidth-1:0] SegB2    = 10'd342;
  localparam logic [SampleWidth-1:0] SegB3    = 10'd512;
  localparam logic [SampleWidth-1:0] SegB4    = 10'd683;
  localparam logic [SampleWidth-1:0] SegB5    = 10'd854;

  localparam logic [LevelWidth-1:0] FullLevel    = 8'd255;
  localparam logic [LevelWidth-1:0] CounterReset = 8'd255;

  typedef logic [LevelWidth-1:0] level_t;
  // index 0 red, 1 green, 2 blue
  typedef level_t [PinWidth-1:0] level_set_t;
  typedef logic [PinWidth-1:0] pins_t;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncTick   = 1'b1
  } func_t;

  typedef struct packed {
    logic  step;
    func_t func;
  } pwm_ctrl_t;

  // offset * 255 / 170 is exactly floor(offset * 3 / 2)
  function automatic logic [LevelWidth:0] ramp_up(input logic [LevelWidth-1:0] offset);
    ramp_up = {1'b0, offset} + {2'b00, offset[LevelWidth-1:1]};
  endfunction

  // Clamp the overshoot at the end of a falling ramp to 0
  function automatic level_t ramp_down(input logic [LevelWidth-1:0] offset);
    logic [LevelWidth:0] r;
    r = ramp_up(offset);
    if (r >= {1'b0, FullLevel}) begin
      ramp_down = '0;
    end else begin
      ramp_down = LevelWidth'({1'b0, FullLevel} - r);
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/crw_if.sv
`default_nettype none

interface crw_in_if import crw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SampleWidth-1:0] sample_value;

  modport source(output valid, output func, output sample_value, input ready);
  modport sink(input valid, input func, input sample_value, output ready);
endinterface

interface crw_out_if import crw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PinWidth-1:0]   led_pins;
  logic [LevelWidth-1:0] red_level;
  logic [LevelWidth-1:0] green_level;
  logic [LevelWidth-1:0] blue_level;

  modport source(output valid, output led_pins, output red_level, output green_level,
                 output blue_level, input ready);
  modport sink(input valid, input led_pins, input red_level, input green_level,
               input blue_level, output ready);
endinterface

`default_nettype wire

// File: rtl/crw_wheel.sv
`default_nettype none

module crw_wheel import crw_pkg::*; (
  input  wire logic [SampleWidth-1:0] sample,
  output level_set_t                  levels
);

  logic [SampleWidth-1:0] diff0;
  logic [SampleWidth-1:0] diff1;
  logic [SampleWidth-1:0] diff2;
  logic [SampleWidth-1:0] diff3;
  logic [SampleWidth-1:0] diff4;

  assign diff0 = sample - SegRange;
  assign diff1 = sample - SegB2;
  assign diff2 = sample - SegB3;
  assign diff3 = sample - SegB4;
  assign diff4 = sample - SegB5;

  always_comb begin
    if (sample < SegRange) begin
      levels[0] = FullLevel;
      levels[1] = LevelWidth'(ramp_up(sample[LevelWidth-1:0]));
      levels[2] = '0;
    end else if (sample < SegB2) begin
      levels[0] = ramp_down(diff0[LevelWidth-1:0]);
      levels[1] = FullLevel;
      levels[2] = '0;
    end else if (sample < SegB3) begin
      levels[0] = '0;
      levels[1] = FullLevel;
      levels[2] = LevelWidth'(ramp_up(diff1[LevelWidth-1:0]));
    end else if (sample < SegB4) begin
      levels[0] = '0;
      levels[1] = ramp_down(diff2[LevelWidth-1:0]);
      levels[2] = FullLevel;
    end else if (sample < SegB5) begin
      levels[0] = LevelWidth'(ramp_up(diff3[LevelWidth-1:0]));
      levels[1] = '0;
      levels[2] = FullLevel;
    end else begin
      levels[0] = FullLevel;
      levels[1] = '0;
      levels[2] = ramp_down(diff4[LevelWidth-1:0]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/crw_pwm.sv
`default_nettype none

module crw_pwm import crw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pwm_ctrl_t  ctrl,
  input  wire level_set_t new_levels,
  output level_set_t targets,
  output pins_t      pins
);

  level_set_t latched;
  level_t     counter;

  level_t     counter_next;
  level_set_t latched_next;
  pins_t      pins_next;

  always_comb begin
    counter_next = counter + 8'd1;
    latched_next = latched;
    pins_next    = pins;
    if (counter_next == '0) begin
      latched_next = targets;
      pins_next    = '0;
    end
    for (int i = 0; i < PinWidth; i++) begin
      if (latched_next[i] == counter_next) begin
        pins_next[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      targets <= '0;
      latched <= '0;
      counter <= CounterReset;
      pins    <= '0;
    end else if (ctrl.step) begin
      if (ctrl.func == FuncSample) begin
        targets <= new_levels;
      end else begin
        latched <= latched_next;
        counter <= counter_next;
        pins    <= pins_next;
      end
    end
  end

  // Latch the targets when the counter wraps
  a_latch_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && ctrl.func == FuncTick && counter == CounterReset)
      |=> (latched == $past(targets) && counter == '0))
    else $error("targets not latched on counter wrap");

  // Counter and latched levels move only on ticks
  a_hold_on_sample: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.step && ctrl.func == FuncTick) |=> ($stable(counter) && $stable(latched)
      && $stable(pins)))
    else $error("pwm state changed without a tick");

  // Red latched at zero is dark from the wrap tick
  a_zero_dark: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && ctrl.func == FuncTick && counter == CounterReset && targets[0] == '0)
      |=> pins[0])
    else $error("red latched at zero not switched off on wrap");

endmodule

`default_nettype wire

// File: rtl/colour_wheel_rgb_pwm_top.sv
// Channel  | Dir | Payload                                          | Handshake
// items    | in  | func, sample_value                               | valid/ready
// results  | out | led_pins, red_level, green_level, blue_level     | valid/ready
//
// One item per cycle sustained while results are taken; each item passes the input
// register, then mapping and PWM update into the result register.
// Synchronous active-high reset: targets and latched levels 0, counter 255, pins 0.
// A stalled result holds the result register; the input register keeps taking items
// while it is empty or the result register is empty or being drained.
`default_nettype none

module colour_wheel_rgb_pwm_top import crw_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  crw_in_if.sink   items,
  crw_out_if.source results
);

  logic                   in_valid;
  func_t                  in_func;
  logic [SampleWidth-1:0] in_sample;

  logic       out_valid;
  pins_t      out_pins;
  level_set_t out_levels;

  logic       advance;
  pwm_ctrl_t  ctrl;
  level_set_t new_levels;
  level_set_t targets;
  pins_t      pins;

  assign advance     = !out_valid || results.ready;
  assign items.ready = !in_valid || advance;
  assign ctrl.step   = in_valid && advance;
  assign ctrl.func   = in_func;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_func   <= func_t'(items.func);
      in_sample <= items.sample_value;
    end
  end

  crw_wheel u_wheel (
    .sample (in_sample),
    .levels (new_levels)
  );

  crw_pwm u_pwm (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .new_levels (new_levels),
    .targets    (targets),
    .pins       (pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Pins report the mask before this item; levels report the targets after it
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_pins   <= pins;
      out_levels <= (in_func == FuncSample) ? new_levels : targets;
    end
  end

  assign results.valid       = out_valid;
  assign results.led_pins    = out_pins;
  assign results.red_level   = out_levels[0];
  assign results.green_level = out_levels[1];
  assign results.blue_level  = out_levels[2];

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb import crw_pkg::*;;

  typedef struct packed {
    pins_t  pins;
    level_t red;
    level_t green;
    level_t blue;
  } led_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crw_in_if  items_if ();
  crw_out_if results_if ();

  colour_wheel_rgb_pwm_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  level_t target_lv [3];
  level_t latched_lv [3];
  level_t pwm_count;
  pins_t  pin_state;

  led_result_t expected_leds [$];
  bit          no_idle = 1'b0;
  int          n_samples = 0;
  int          n_ticks = 0;
  int          n_checked = 0;
  int          n_errors = 0;

  initial begin
    items_if.valid        = 1'b0;
    items_if.func         = FuncSample;
    items_if.sample_value = '0;
    results_if.ready      = 1'b0;
  end

  function automatic level_t ramp_rise(int unsigned offset);
    return level_t'((offset * 255) / 170);
  endfunction

  // falling ramp: clamp the overshoot at the end of the segment to dark
  function automatic level_t ramp_fall(int unsigned offset);
    int unsigned r;
    r = (offset * 255) / 170;
    if (r >= 255) return '0;
    return level_t'(255 - r);
  endfunction

  task automatic reset_wheel_model();
    for (int i = 0; i < 3; i++) begin
      target_lv[i]  = '0;
      latched_lv[i] = '0;
    end
    pwm_count = 8'd255;
    pin_state = '0;
  endtask

  function automatic led_result_t predict_wheel_pwm(func_t f, logic [SampleWidth-1:0] sv);
    led_result_t res;
    int unsigned s;
    s = sv;
    res.pins = pin_state;
    if (f == FuncSample) begin
      if (s < 170) begin
        target_lv[0] = 8'd255; target_lv[1] = ramp_rise(s); target_lv[2] = 8'd0;
      end else if (s < 342) begin
        target_lv[0] = ramp_fall(s - 170); target_lv[1] = 8'd255; target_lv[2] = 8'd0;
      end else if (s < 512) begin
        target_lv[0] = 8'd0; target_lv[1] = 8'd255; target_lv[2] = ramp_rise(s - 342);
      end else if (s < 683) begin
        target_lv[0] = 8'd0; target_lv[1] = ramp_fall(s - 512); target_lv[2] = 8'd255;
      end else if (s < 854) begin
        target_lv[0] = ramp_rise(s - 683); target_lv[1] = 8'd0; target_lv[2] = 8'd255;
      end else begin
        target_lv[0] = 8'd255; target_lv[1] = 8'd0; target_lv[2] = ramp_fall(s - 854);
      end
    end else begin
      pwm_count = pwm_count + 8'd1;
      // wrap: latch new targets and switch every LED on
      if (pwm_count == 8'd0) begin
        for (int i = 0; i < 3; i++) latched_lv[i] = target_lv[i];
        pin_state = '0;
      end
      for (int i = 0; i < 3; i++) begin
        if (latched_lv[i] == pwm_count) pin_state[i] = 1'b1;
      end
    end
    res.red   = target_lv[0];
    res.green = target_lv[1];
    res.blue  = target_lv[2];
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(func_t f, logic [SampleWidth-1:0] sv);
    while (!no_idle && $urandom_range(99) < 18) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.func         <= f;
    items_if.sample_value <= sv;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    expected_leds.push_back(predict_wheel_pwm(f, sv));
    if (f == FuncSample) n_samples++;
    else n_ticks++;
    @(negedge clk);
  endtask

  task automatic send_sample(logic [SampleWidth-1:0] sv);
    send_item(FuncSample, sv);
  endtask

  task automatic send_tick();
    send_item(FuncTick, SampleWidth'($urandom_range(0, 1023)));
  endtask

  function automatic logic [SampleWidth-1:0] pick_sample();
    logic [SampleWidth-1:0] edges [14] = '{10'd0, 10'd169, 10'd170, 10'd171, 10'd340,
                                           10'd341, 10'd342, 10'd511, 10'd512, 10'd682,
                                           10'd683, 10'd853, 10'd854, 10'd1023};
    if ($urandom_range(3) == 0) return edges[$urandom_range(0, 13)];
    return SampleWidth'($urandom_range(0, 1023));
  endfunction

  // results side: random back-pressure unless a steady stretch is running
  always @(negedge clk) begin
    results_if.ready <= no_idle || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    led_result_t exp_r;
    led_result_t act_r;
    if (!rst && results_if.valid && results_if.ready) begin
      act_r.pins  = results_if.led_pins;
      act_r.red   = results_if.red_level;
      act_r.green = results_if.green_level;
      act_r.blue  = results_if.blue_level;
      if (expected_leds.size() == 0) begin
        $display("%0t: unexpected result pins=%0h r=%0d g=%0d b=%0d", $time,
                 act_r.pins, act_r.red, act_r.green, act_r.blue);
        n_errors++;
      end else begin
        exp_r = expected_leds.pop_front();
        n_checked++;
        if (act_r.pins !== exp_r.pins) begin
          $display("%0t: led_pins expected %0h actual %0h", $time, exp_r.pins, act_r.pins);
          n_errors++;
        end
        if (act_r.red !== exp_r.red) begin
          $display("%0t: red_level expected %0d actual %0d", $time, exp_r.red, act_r.red);
          n_errors++;
        end
        if (act_r.green !== exp_r.green) begin
          $display("%0t: green_level expected %0d actual %0d", $time,
                   exp_r.green, act_r.green);
          n_errors++;
        end
        if (act_r.blue !== exp_r.blue) begin
          $display("%0t: blue_level expected %0d actual %0d", $time, exp_r.blue, act_r.blue);
          n_errors++;
        end
      end
    end
  end

  // after reset the targets are zero, so the first wrap leaves every LED dark
  task automatic test_reset_dark();
    repeat (3) send_tick();
  endtask

  task automatic test_wheel_segments();
    logic [SampleWidth-1:0] edges [14] = '{10'd0, 10'd169, 10'd170, 10'd171, 10'd340,
                                           10'd341, 10'd342, 10'd511, 10'd512, 10'd682,
                                           10'd683, 10'd853, 10'd854, 10'd1023};
    for (int i = 0; i < 14; i++) begin
      send_sample(edges[i]);
      if (i % 3 == 2) send_tick();
    end
    send_tick();
  endtask

  // sample, then a run of ticks; the runs add up to pass compare points and wraps
  task automatic test_pwm_sequences();
    int sent;
    int run;
    sent = 0;
    while (sent < 250) begin
      if ($urandom_range(7) == 0) begin
        run = $urandom_range(1, 4);
        repeat (run) send_sample(pick_sample());
        sent += run;
      end
      send_sample(pick_sample());
      run = $urandom_range(20, 160);
      repeat (run) send_tick();
      sent += run + 1;
    end
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    repeat (150) begin
      if ($urandom_range(9) == 0) send_sample(pick_sample());
      else send_tick();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    reset_wheel_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_dark();
    test_wheel_segments();
    test_pwm_sequences();
    test_steady_stream();
    items_if.valid <= 1'b0;

    while (expected_leds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d wheel samples and %0d PWM ticks; %0d results compared.",
             n_samples, n_ticks, n_checked);
    $display("Segment edges, red fall clamp, dark channels and full PWM wraps exercised.");
    if (n_errors == 0 && expected_leds.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/crw_pkg.sv
rtl/crw_if.sv
rtl/crw_wheel.sv
rtl/crw_pwm.sv
rtl/colour_wheel_rgb_pwm_top.sv
dv/tb.sv
